@@ rtl/core/qar_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package qar_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC,
		ST_SQSUM,
		ST_SQRT,
		ST_DIV,
		ST_OUT
	} qar_state_t;

	typedef struct packed {
		logic       valid;
		logic       clr;
		logic       neg;
		logic       last;
		logic [1:0] tag;
	} mac_ctl_t;

	typedef struct packed {
		logic [1:0] s_idx;
		logic [1:0] a_idx;
		logic       neg;
	} prod_sel_t;

	localparam int unsigned QW      = 16;
	localparam int unsigned ACC_W   = 35;
	localparam int unsigned SQ_IN_W = 49;
	localparam int unsigned SQ_RT_W = 25;
	localparam int unsigned NUM_W   = 39;
	localparam int unsigned DEN_W   = 26;

	// Operand selection for the sixteen products of the quaternion product.
	// Component k uses terms 4k to 4k+3; the spin index and the stored index
	// pick the multiplicands, and neg subtracts the product.
	function automatic prod_sel_t term_sel(input logic [3:0] idx);
		prod_sel_t r;
		case (idx)
			4'd0:    r = '{2'd0, 2'd3, 1'b0};
			4'd1:    r = '{2'd3, 2'd0, 1'b0};
			4'd2:    r = '{2'd2, 2'd1, 1'b0};
			4'd3:    r = '{2'd1, 2'd2, 1'b1};
			4'd4:    r = '{2'd1, 2'd3, 1'b0};
			4'd5:    r = '{2'd3, 2'd1, 1'b0};
			4'd6:    r = '{2'd0, 2'd2, 1'b0};
			4'd7:    r = '{2'd2, 2'd0, 1'b1};
			4'd8:    r = '{2'd2, 2'd3, 1'b0};
			4'd9:    r = '{2'd3, 2'd2, 1'b0};
			4'd10:   r = '{2'd1, 2'd0, 1'b0};
			4'd11:   r = '{2'd0, 2'd1, 1'b1};
			4'd12:   r = '{2'd3, 2'd3, 1'b0};
			4'd13:   r = '{2'd0, 2'd0, 1'b1};
			4'd14:   r = '{2'd1, 2'd1, 1'b1};
			4'd15:   r = '{2'd2, 2'd2, 1'b1};
			default: r = '{2'd0, 2'd0, 1'b0};
		endcase
		return r;
	endfunction

	// Applies a sign to a magnitude and saturates to 16 bits.
	function automatic logic [QW-1:0] sat16(input logic neg, input logic [20:0] mag);
		logic [QW-1:0] r;
		if (neg) begin
			r = (mag > 21'd32768) ? 16'h8000 : QW'(~mag[15:0] + 16'd1);
		end else begin
			r = (mag > 21'd32767) ? 16'h7fff : mag[15:0];
		end
		return r;
	endfunction

	// Rounds a Q2.28 sum to Q1.14, ties away from zero, then saturates.
	function automatic logic [QW-1:0] rnd_q14(input logic [ACC_W-1:0] sum);
		logic [ACC_W-1:0] mag;
		logic [ACC_W-1:0] rnd;
		mag = sum[ACC_W-1] ? (~sum + ACC_W'(1)) : sum;
		rnd = mag + ACC_W'(8192);
		return sat16(sum[ACC_W-1], rnd[34:14]);
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/quaternion_accumulate_renorm_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Composes each incoming rotation word with the stored orientation quaternion
// and returns the new orientation as one output word, with m_tuser set when the
// item took the renormalization path. All sixteen products run through one
// shared 16x16 multiply-accumulate unit, one product per cycle; the block is
// ready again only after the output has been taken on m_tready. Once the
// composition count passes the renorm_interval register, the item also sums
// the four squares on the same unit and, unless that sum is zero, extracts a
// 25-bit square root one bit per cycle and divides each component with a
// 16-step restoring divider. The block takes one input word at a time;
// renorm_interval is written through the cfg channel, and the user must write
// it only while the block is idle; the block itself does not enforce this.
module quaternion_accumulate_renorm_unit import qar_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // spin_x, spin_y, spin_z, spin_w
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // out_x, out_y, out_z, out_w
	output logic [0:0]  m_tuser,   // renormalized
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [9:0]  cfg_data
);

	qar_state_t          state_q;
	qar_state_t          state_d;
	logic [4:0]          cnt_q;
	logic [9:0]          interval_q;
	logic [9:0]          count_q;
	logic                renorm_q;
	logic [QW-1:0]       spin_q   [4];
	logic [QW-1:0]       orient_q [4];
	logic [QW-1:0]       res_q    [4];

	prod_sel_t           sel;
	logic                renorm_now;
	logic [10:0]         count_next;

	mac_ctl_t            mac_ctl;
	logic signed [QW-1:0] mac_a;
	logic signed [QW-1:0] mac_b;
	logic                mac_done;
	logic [1:0]          mac_tag;
	logic [ACC_W-1:0]    mac_sum;

	logic                sqrt_start;
	logic [SQ_IN_W-1:0]  sqrt_x;
	logic                sqrt_done;
	logic [SQ_RT_W-1:0]  sqrt_root;

	logic                div_start;
	logic [1:0]          div_idx;
	logic [QW-1:0]       div_r;
	logic [QW-1:0]       div_mag;
	logic [NUM_W-1:0]    div_num;
	logic [DEN_W-1:0]    div_den;
	logic                div_done;
	logic [QW-1:0]       div_quo;
	logic [QW-1:0]       div_res;

	assign sel        = term_sel(cnt_q[3:0]);
	assign count_next = {1'b0, count_q} + 11'd1;
	assign renorm_now = count_next > {1'b0, interval_q};

	assign sqrt_x  = {mac_sum[32:0], 16'd0};
	assign div_r   = res_q[div_idx];
	assign div_mag = div_r[QW-1] ? (~div_r + 16'd1) : div_r;
	assign div_num = {div_mag, 23'd0} + NUM_W'(sqrt_root);
	assign div_den = {sqrt_root, 1'b0};
	assign div_res = sat16(res_q[cnt_q[1:0]][QW-1], {5'd0, div_quo});

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (s_tvalid) state_d = ST_MAC;
			ST_MAC: begin
				if (mac_done && (mac_tag == 2'd3)) begin
					state_d = renorm_now ? ST_SQSUM : ST_OUT;
				end
			end
			ST_SQSUM: begin
				if (mac_done) begin
					state_d = (mac_sum != '0) ? ST_SQRT : ST_OUT;
				end
			end
			ST_SQRT:  if (sqrt_done) state_d = ST_DIV;
			ST_DIV: begin
				if (div_done && (cnt_q[1:0] == 2'd3)) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT:   if (m_tready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready   = 1'b0;
		m_tvalid   = 1'b0;
		mac_ctl    = '0;
		mac_a      = spin_q[sel.s_idx];
		mac_b      = orient_q[sel.a_idx];
		sqrt_start = 1'b0;
		div_start  = 1'b0;
		div_idx    = cnt_q[1:0] + 2'd1;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
			end
			ST_MAC: begin
				mac_ctl.valid = !cnt_q[4];
				mac_ctl.clr   = cnt_q[1:0] == 2'd0;
				mac_ctl.neg   = sel.neg;
				mac_ctl.last  = cnt_q[1:0] == 2'd3;
				mac_ctl.tag   = cnt_q[3:2];
			end
			ST_SQSUM: begin
				mac_a         = res_q[cnt_q[1:0]];
				mac_b         = res_q[cnt_q[1:0]];
				mac_ctl.valid = cnt_q[4:2] == 3'd0;
				mac_ctl.clr   = cnt_q[1:0] == 2'd0;
				mac_ctl.last  = cnt_q[1:0] == 2'd3;
				sqrt_start    = mac_done && (mac_sum != '0);
			end
			ST_SQRT: begin
				div_idx   = 2'd0;
				div_start = sqrt_done;
			end
			ST_DIV: begin
				div_start = div_done && (cnt_q[1:0] != 2'd3);
			end
			ST_OUT: begin
				m_tvalid = 1'b1;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			interval_q  <= 10'd97;
			count_q     <= '0;
			renorm_q    <= 1'b0;
			orient_q[0] <= '0;
			orient_q[1] <= '0;
			orient_q[2] <= '0;
			orient_q[3] <= 16'd16384;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				interval_q <= cfg_data;
			end
			case (state_q)
				ST_IDLE: cnt_q <= '0;
				ST_MAC: begin
					if (mac_done && (mac_tag == 2'd3)) begin
						cnt_q    <= '0;
						renorm_q <= renorm_now;
						count_q  <= renorm_now ? 10'd0 : count_next[9:0];
					end else if (!cnt_q[4]) begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				ST_SQSUM: if (cnt_q[4:2] == 3'd0) cnt_q <= cnt_q + 5'd1;
				ST_SQRT:  cnt_q <= '0;
				ST_DIV:   if (div_done) cnt_q <= cnt_q + 5'd1;
				ST_OUT: begin
					if (m_tready) begin
						orient_q <= res_q;
					end
				end
				default: cnt_q <= '0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			spin_q[0] <= s_tdata[15:0];
			spin_q[1] <= s_tdata[31:16];
			spin_q[2] <= s_tdata[47:32];
			spin_q[3] <= s_tdata[63:48];
		end
		if ((state_q == ST_MAC) && mac_done) begin
			res_q[mac_tag] <= rnd_q14(mac_sum);
		end
		if ((state_q == ST_DIV) && div_done) begin
			res_q[cnt_q[1:0]] <= div_res;
		end
	end

	qar_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.a      (mac_a),
		.b      (mac_b),
		.done   (mac_done),
		.tag    (mac_tag),
		.sum    (mac_sum)
	);

	qar_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.x      (sqrt_x),
		.done   (sqrt_done),
		.root   (sqrt_root)
	);

	qar_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign cfg_ready = 1'b1;
	assign m_tdata   = {res_q[3], res_q[2], res_q[1], res_q[0]};
	assign m_tuser   = renorm_q;

`ifndef SYNTH
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input accepted while a result is pending");
	a_renorm_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (count_q == 10'd0))
		else $error("renormalized result left the composition count running");
	a_plain_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> (count_q != 10'd0))
		else $error("plain result did not advance the composition count");
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == ST_MAC))
		else $error("accepted word did not start a composition");
`endif

endmodule

`default_nettype wire

@@ rtl/core/qar_mac.sv @@
`timescale 1ns / 1ps
`default_nettype none

module qar_mac import qar_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  mac_ctl_t                ctl,
	input  logic signed [QW-1:0]    a,
	input  logic signed [QW-1:0]    b,
	output logic                    done,
	output logic [1:0]              tag,
	output logic [ACC_W-1:0]        sum
);

	mac_ctl_t                ctl_s1;
	logic signed [2*QW-1:0]  prod_s1;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] base;
	logic [1:0]              tag_q;
	logic                    done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			done_q <= 1'b0;
		end else begin
			ctl_s1 <= ctl;
			done_q <= ctl_s1.valid && ctl_s1.last;
		end
	end

	assign base = ctl_s1.clr ? '0 : acc_q;

	always_ff @(posedge clk) begin
		prod_s1 <= a * b;
		if (ctl_s1.valid) begin
			acc_q <= ctl_s1.neg ? (base - ACC_W'(prod_s1)) : (base + ACC_W'(prod_s1));
			tag_q <= ctl_s1.tag;
		end
	end

	assign done = done_q;
	assign tag  = tag_q;
	assign sum  = acc_q;

endmodule

`default_nettype wire

@@ rtl/core/qar_sqrt.sv @@
`timescale 1ns / 1ps
`default_nettype none

module qar_sqrt import qar_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [SQ_IN_W-1:0]   x,
	output logic                 done,
	output logic [SQ_RT_W-1:0]   root
);

	logic               busy_q;
	logic               done_q;
	logic [SQ_IN_W-1:0] n_q;
	logic [SQ_IN_W:0]   res_q;
	logic [SQ_IN_W-1:0] bit_q;
	logic [SQ_IN_W:0]   trial;
	logic               ge;

	assign trial = res_q + {1'b0, bit_q};
	assign ge    = {1'b0, n_q} >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q[0]) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// One result bit per cycle, two radicand bits consumed per step.
	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= x;
			res_q <= '0;
			bit_q <= {1'b1, {(SQ_IN_W-1){1'b0}}};
		end else if (busy_q) begin
			if (ge) begin
				n_q   <= n_q - trial[SQ_IN_W-1:0];
				res_q <= (res_q >> 1) + {1'b0, bit_q};
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = res_q[SQ_RT_W-1:0];

`ifndef SYNTH
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy_q))
		else $error("root finished without a running extraction");
`endif

endmodule

`default_nettype wire

@@ rtl/core/qar_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

module qar_div import qar_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [NUM_W-1:0]   num,
	input  logic [DEN_W-1:0]   den,
	output logic               done,
	output logic [QW-1:0]      quo
);

	localparam int unsigned DSH_W = DEN_W + QW - 1;

	logic             busy_q;
	logic             done_q;
	logic [3:0]       cnt_q;
	logic [NUM_W-1:0] rem_q;
	logic [DSH_W-1:0] dsh_q;
	logic [QW-1:0]    quo_q;
	logic             ge;

	assign ge = {{(DSH_W-NUM_W){1'b0}}, rem_q} >= dsh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'd15) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Restoring division, one quotient bit per cycle, most significant first.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			dsh_q <= {den, {(QW-1){1'b0}}};
			quo_q <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - dsh_q[NUM_W-1:0];
			end
			quo_q <= {quo_q[QW-2:0], ge};
			dsh_q <= dsh_q >> 1;
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

`default_nettype wire

@@ tb/sv/qar_result_checker.sv @@
`timescale 1ns / 1ps

module qar_result_checker import qar_pkg::QW; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	input  logic            s_tready,
	input  logic [4*QW-1:0] s_tdata,
	input  logic            m_tvalid,
	input  logic            m_tready,
	input  logic [4*QW-1:0] m_tdata,
	input  logic [0:0]      m_tuser,
	input  logic            cfg_valid,
	input  logic            cfg_ready,
	input  logic [9:0]      cfg_data,
	output int              mismatches,
	output int              outstanding
);

	localparam longint UNIT = 16384;

	typedef struct packed {
		logic               renorm;
		logic [3:0][QW-1:0] comp;
	} orientation_t;

	orientation_t       expected_q [$];
	logic [3:0][QW-1:0] orient;
	logic [9:0]         compose_count;
	logic [9:0]         renorm_interval;
	int                 results_seen;
	string              lanes = "xyzw";

	function automatic longint div_nearest(longint num, longint den);
		longint mag;
		longint q;
		mag = (num < 0) ? -num : num;
		q = (mag + den / 2) / den;
		return (num < 0) ? -q : q;
	endfunction

	function automatic logic [QW-1:0] clamp_q14(longint v);
		if (v > 32767) begin
			v = 32767;
		end else if (v < -32768) begin
			v = -32768;
		end
		return QW'(v);
	endfunction

	function automatic longint isqrt_floor(longint n);
		longint r;
		longint t;
		int b;
		r = 0;
		for (b = 24; b >= 0; b--) begin
			t = r | (longint'(1) << b);
			if (t * t <= n) begin
				r = t;
			end
		end
		return r;
	endfunction

	// Composes one spin word with the stored orientation and advances the
	// composition count, renormalizing when the count passes the interval.
	function automatic orientation_t compose_spin(logic [4*QW-1:0] word);
		longint       sp [4];
		longint       ac [4];
		longint       prod [4];
		longint       sumsq;
		longint       mag;
		logic [10:0]  advanced;
		orientation_t res;
		int           i;
		for (i = 0; i < 4; i++) begin
			sp[i] = longint'($signed(word[QW*i +: QW]));
			ac[i] = longint'($signed(orient[i]));
		end
		prod[0] = sp[0] * ac[3] + ac[0] * sp[3] + ac[1] * sp[2] - ac[2] * sp[1];
		prod[1] = sp[1] * ac[3] + ac[1] * sp[3] + ac[2] * sp[0] - ac[0] * sp[2];
		prod[2] = sp[2] * ac[3] + ac[2] * sp[3] + ac[0] * sp[1] - ac[1] * sp[0];
		prod[3] = sp[3] * ac[3] - sp[0] * ac[0] - sp[1] * ac[1] - sp[2] * ac[2];
		for (i = 0; i < 4; i++) begin
			res.comp[i] = clamp_q14(div_nearest(prod[i], UNIT));
		end
		advanced = {1'b0, compose_count} + 11'd1;
		res.renorm = (advanced > {1'b0, renorm_interval});
		if (res.renorm) begin
			compose_count = '0;
			sumsq = 0;
			for (i = 0; i < 4; i++) begin
				ac[i] = longint'($signed(res.comp[i]));
				sumsq += ac[i] * ac[i];
			end
			if (sumsq != 0) begin
				mag = isqrt_floor(sumsq << 16);
				for (i = 0; i < 4; i++) begin
					res.comp[i] = clamp_q14(div_nearest(ac[i] <<< 22, mag));
				end
			end
		end else begin
			compose_count = advanced[9:0];
		end
		orient = res.comp;
		return res;
	endfunction

	task automatic flag_mismatch(string msg);
		$display("ERROR at %0t ns: %s", $time, msg);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		orientation_t got;
		orientation_t want;
		int i;
		if (!arst_n) begin
			renorm_interval = 10'd97;
			orient = {QW'(UNIT), QW'(0), QW'(0), QW'(0)};
			compose_count = '0;
			expected_q.delete();
			results_seen = 0;
			mismatches = 0;
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				renorm_interval = cfg_data;
			end
			if (m_tvalid && m_tready) begin
				got.comp = m_tdata;
				got.renorm = m_tuser[0];
				if (expected_q.size() == 0) begin
					flag_mismatch($sformatf("result %0d arrived with no spin word pending",
						results_seen));
				end else begin
					want = expected_q.pop_front();
					for (i = 0; i < 4; i++) begin
						if (got.comp[i] != want.comp[i]) begin
							flag_mismatch($sformatf("result %0d out_%c: got %0d, expected %0d",
								results_seen, lanes[i], $signed(got.comp[i]),
								$signed(want.comp[i])));
						end
					end
					if (got.renorm != want.renorm) begin
						flag_mismatch($sformatf("result %0d renormalized: got %0b, expected %0b",
							results_seen, got.renorm, want.renorm));
					end
				end
				results_seen++;
			end
			if (s_tvalid && s_tready) begin
				expected_q = {expected_q, compose_spin(s_tdata)};
			end
			outstanding <= expected_q.size();
		end
	end

endmodule

@@ tb/sv/tb_quaternion_accumulate_renorm_unit.sv @@
`timescale 1ns / 1ps

module tb_quaternion_accumulate_renorm_unit;

	import qar_pkg::QW;

	localparam int STALL_LIMIT  = 2000;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 40;

	logic            clk;
	logic            arst_n;
	logic            s_tvalid;
	logic            s_tready;
	logic [4*QW-1:0] s_tdata;   // spin_x, spin_y, spin_z, spin_w
	logic            m_tvalid;
	logic            m_tready;
	logic [4*QW-1:0] m_tdata;   // out_x, out_y, out_z, out_w
	logic [0:0]      m_tuser;   // renormalized
	logic            cfg_valid;
	logic            cfg_ready;
	logic [9:0]      cfg_data;

	int   mismatches;
	int   outstanding;
	int   send_pct;
	int   recv_pct;
	int   hold_reqs;

	quaternion_accumulate_renorm_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	qar_result_checker orient_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [4*QW-1:0] spin_word(int x, int y, int z, int w);
		return {QW'(w), QW'(z), QW'(y), QW'(x)};
	endfunction

	// Mostly small rotations near identity, some large ones, some raw noise.
	function automatic logic [4*QW-1:0] random_spin();
		int pick;
		int x;
		int y;
		int z;
		int w;
		pick = $urandom_range(99);
		if (pick < 70) begin
			x = int'($urandom_range(4000)) - 2000;
			y = int'($urandom_range(4000)) - 2000;
			z = int'($urandom_range(4000)) - 2000;
			w = 16384 - int'($urandom_range(600));
			if ($urandom_range(9) == 0) begin
				w = -w;
			end
		end else if (pick < 85) begin
			x = int'($urandom_range(23170)) - 11585;
			y = int'($urandom_range(23170)) - 11585;
			z = int'($urandom_range(23170)) - 11585;
			w = int'($urandom_range(23170)) - 11585;
		end else begin
			return {$urandom, $urandom};
		end
		return spin_word(x, y, z, w);
	endfunction

	task automatic offer_spin(logic [4*QW-1:0] word);
		while (int'($urandom_range(99)) < send_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= word;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic write_interval(int value);
		settle();
		cfg_valid <= 1'b1;
		cfg_data <= 10'(value);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(int interval, bit rewrite, int s_pct, int r_pct, int items,
			bit hold, bit pause);
		int n;
		if (rewrite) begin
			write_interval(interval);
		end
		send_pct = s_pct;
		recv_pct = r_pct;
		for (n = 0; n < items; n++) begin
			if (hold && n == items / 2) begin
				hold_reqs <= hold_reqs + 1;
			end
			if (pause && n == items / 2) begin
				settle();
			end
			offer_spin(random_spin());
		end
	endtask

	initial begin
		int holds_served;
		holds_served = 0;
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_reqs != holds_served) begin
				holds_served++;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			m_tready <= (int'($urandom_range(99)) >= recv_pct);
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("tb: failure");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		hold_reqs = 0;
		send_pct = 0;
		recv_pct = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		offer_spin(spin_word(0, 0, 0, 16384));
		offer_spin(spin_word(32767, 32767, 32767, 32767));
		offer_spin(spin_word(-32768, -32768, -32768, -32768));
		offer_spin(spin_word(32767, -32768, 0, -1));
		offer_spin(spin_word(-1, 0, -32768, 32767));
		offer_spin(spin_word(21845, -21846, 21845, -21846));

		write_interval(0);
		offer_spin(spin_word(0, 0, 11585, 11585));
		offer_spin(spin_word(11585, 0, 0, -11585));
		offer_spin(spin_word(1, 0, 0, 0));
		offer_spin(spin_word(0, -1, 0, 0));
		offer_spin(spin_word(-32768, 0, 0, 0));
		offer_spin(spin_word(0, 0, 0, 32767));

		write_interval(1);
		offer_spin(spin_word(0, 0, 0, -32768));
		offer_spin(spin_word(8192, 8192, 8192, 8192));
		offer_spin(spin_word(0, 0, 0, 16384));
		offer_spin(spin_word(-8192, 0, 8192, -16384));

		write_interval(2);
		offer_spin(spin_word(100, -100, 50, 16380));
		offer_spin(spin_word(0, 0, 0, 1));
		offer_spin(spin_word(-2000, 3000, -1000, 16000));

		run_phase(3, 1'b1, 0, 0, 30, 1'b0, 1'b0);
		run_phase(1, 1'b1, 79, 0, 30, 1'b0, 1'b0);
		run_phase(7, 1'b1, 0, 79, 30, 1'b0, 1'b0);
		run_phase(0, 1'b1, 7, 7, 30, 1'b0, 1'b0);
		// The count starts from zero here, so the 401st word of this stretch
		// is the first one renormalized.
		run_phase(400, 1'b1, 0, 0, 105, 1'b0, 1'b0);
		run_phase(400, 1'b0, 79, 0, 105, 1'b0, 1'b0);
		run_phase(400, 1'b0, 0, 79, 105, 1'b0, 1'b1);
		run_phase(400, 1'b0, 7, 7, 105, 1'b1, 1'b0);
		run_phase(97, 1'b1, 0, 0, 60, 1'b1, 1'b0);
		run_phase(5, 1'b1, 79, 0, 30, 1'b0, 1'b1);

		// An all-zero orientation can never leave zero again, so this comes last.
		write_interval(0);
		send_pct = 0;
		recv_pct = 0;
		offer_spin(spin_word(0, 0, 0, 0));
		offer_spin(random_spin());
		offer_spin(spin_word(32767, 32767, 32767, 32767));

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
